// ----- design/u8df_pkg.sv -----
// u8df_pkg: shared types and constants for the UTF-8 decode filter.
// No dependencies.
package u8df_pkg;

    localparam int CP_W = 21;

    localparam logic [7:0] MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] CODE_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] CODE_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] CODE_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_CONT   = 8'hC0;
    localparam logic [7:0] CODE_CONT   = 8'h80;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_DEL      = 21'h00007F;
    localparam logic [CP_W-1:0] CP_SPACE    = 21'h000020;
    localparam logic [CP_W-1:0] CP_TAB      = 21'h000009;
    localparam logic [CP_W-1:0] CP_LF       = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR       = 21'h00000D;

    typedef enum logic [1:0] {
        RUN_OK        = 2'd0,
        RUN_MALFORMED = 2'd1,
        RUN_EMPTY     = 2'd2
    } run_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic              has_result;
        logic [CP_W-1:0]   code_point;
        logic              point_valid;
        logic              run_done;
        run_status_t       run_status;
    } dec_out_t;

endpackage

// ----- design/u8df_in_reg.sv -----
// u8df_in_reg: input register stage of the UTF-8 decode filter.
// Depends on u8df_pkg.
module u8df_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  u8df_pkg::in_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output u8df_pkg::in_item_t item
);
    import u8df_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- design/u8df_decode.sv -----
// u8df_decode: run state and combinational UTF-8 decode, check and filter.
// Depends on u8df_pkg.
module u8df_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  u8df_pkg::in_item_t  item,
    input  logic                advance,
    output u8df_pkg::dec_out_t  result
);
    import u8df_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      pending_reg, pending_next;
    logic            error_reg, error_next;
    logic            any_reg, any_next;

    logic [7:0]      c;
    logic            last;
    logic            complete;
    logic [CP_W-1:0] v;
    logic [CP_W-1:0] cp;
    logic            kept;

    assign c    = item.data_byte;
    assign last = item.last_byte;

    always_comb begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        error_next   = error_reg;
        any_next     = any_reg;
        complete     = 1'b0;
        v            = '0;
        cp           = '0;
        kept         = 1'b0;

        if (!error_reg) begin
            if (pending_reg == 2'd0) begin
                priority if (c[7] == 1'b0) begin
                    complete = 1'b1;
                    v        = {{(CP_W-8){1'b0}}, c};
                end else if ((c & MASK_LEAD2) == CODE_LEAD2) begin
                    partial_next = {{(CP_W-5){1'b0}}, c[4:0]};
                    pending_next = 2'd1;
                end else if ((c & MASK_LEAD3) == CODE_LEAD3) begin
                    partial_next = {{(CP_W-4){1'b0}}, c[3:0]};
                    pending_next = 2'd2;
                end else if ((c & MASK_LEAD4) == CODE_LEAD4) begin
                    partial_next = {{(CP_W-3){1'b0}}, c[2:0]};
                    pending_next = 2'd3;
                end else begin
                    error_next = 1'b1;
                end
            end else if ((c & MASK_CONT) == CODE_CONT) begin
                partial_next = {partial_reg[CP_W-7:0], c[5:0]};
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1) begin
                    complete     = 1'b1;
                    v            = {partial_reg[CP_W-7:0], c[5:0]};
                    partial_next = '0;
                end
            end else begin
                error_next = 1'b1;
            end

            // check and filter a finished value
            if (complete) begin
                if (v > CP_MAX || (v >= CP_SURR_LO && v <= CP_SURR_HI)) begin
                    error_next = 1'b1;
                end else if (v == CP_TAB || v == CP_LF || v == CP_CR) begin
                    kept = 1'b1;
                    cp   = CP_SPACE;
                end else if (v >= CP_SPACE && v != CP_DEL) begin
                    kept = 1'b1;
                    cp   = v;
                end
            end

            if (error_next) begin
                partial_next = '0;
                pending_next = 2'd0;
            end
        end

        if (last && pending_next != 2'd0) begin
            error_next = 1'b1;
        end
        if (error_next) begin
            kept = 1'b0;
        end
        if (kept) begin
            any_next = 1'b1;
        end

        result.has_result  = item_valid && (kept || last);
        result.code_point  = kept ? cp : '0;
        result.point_valid = kept;
        result.run_done    = last;
        if (!last) begin
            result.run_status = RUN_OK;
        end else if (error_next) begin
            result.run_status = RUN_MALFORMED;
        end else if (any_next) begin
            result.run_status = RUN_OK;
        end else begin
            result.run_status = RUN_EMPTY;
        end

        // clear everything at run end
        if (last) begin
            partial_next = '0;
            pending_next = 2'd0;
            error_next   = 1'b0;
            any_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            pending_reg <= 2'd0;
            error_reg   <= 1'b0;
            any_reg     <= 1'b0;
        end else if (advance) begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            error_reg   <= error_next;
            any_reg     <= any_next;
        end
    end

    a_pending_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd0 |-> !error_reg && !any_reg || pending_reg != 2'd0 && !error_reg)
        else $error("continuation pending while run marked malformed");

    a_run_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.last_byte |=>
            pending_reg == 2'd0 && !error_reg && !any_reg && partial_reg == '0)
        else $error("run state not cleared after last byte");

    a_kept_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        result.point_valid |-> result.code_point <= CP_MAX && result.code_point >= CP_SPACE
            && result.code_point != CP_DEL)
        else $error("kept code point outside allowed range");

    a_malformed_no_point: assert property (@(posedge aclk) disable iff (!aresetn)
        result.run_done && result.run_status == RUN_MALFORMED |-> !result.point_valid)
        else $error("code point kept on malformed run end");

endmodule

// ----- design/u8df_out_reg.sv -----
// u8df_out_reg: result register of the UTF-8 decode filter.
// Depends on u8df_pkg.
module u8df_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  u8df_pkg::dec_out_t result,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [20:0]        m_code_point,
    output logic               m_point_valid,
    output logic               m_run_done,
    output logic [1:0]         m_run_status
);
    import u8df_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dec_out_t data_reg;

    assign out_free      = !valid_reg || m_ready;
    assign m_valid       = valid_reg;
    assign m_code_point  = data_reg.code_point;
    assign m_point_valid = data_reg.point_valid;
    assign m_run_done    = data_reg.run_done;
    assign m_run_status  = data_reg.run_status;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(data_reg))
        else $error("result changed while stalled");

    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> out_free)
        else $error("result register overwritten");

    a_result_meaningful: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> result.point_valid || result.run_done)
        else $error("empty result loaded");

endmodule

// ----- design/utf8_decode_filter.sv -----
// utf8_decode_filter: streaming UTF-8 decoder with control filtering and run status.
// Depends on u8df_pkg, u8df_in_reg, u8df_decode, u8df_out_reg.
//
//   channel  | ports                                              | direction
//   input    | s_valid s_ready s_data_byte s_last_byte             | in
//   result   | m_valid m_ready m_code_point m_point_valid          | out
//            | m_run_done m_run_status                             |
//
// One byte per cycle sustained while results are taken; a result passes the input register
// and then the result register before it is presented.
// Input register, combinational decode logic, result register; run state updates as a
// byte leaves the input register.
// Bytes that yield no result are consumed without touching the result register.
// A stalled result holds the input register while its byte yields a result; aresetn clears all run state.
module utf8_decode_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_code_point,
    output logic        m_point_valid,
    output logic        m_run_done,
    output logic [1:0]  m_run_status
);
    import u8df_pkg::*;

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     out_free;
    dec_out_t result;

    assign s_item.data_byte = s_data_byte;
    assign s_item.last_byte = s_last_byte;

    assign advance = item_valid && (!result.has_result || out_free);

    u8df_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    u8df_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .result     (result)
    );

    u8df_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && result.has_result),
        .result        (result),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_point_valid (m_point_valid),
        .m_run_done    (m_run_done),
        .m_run_status  (m_run_status)
    );

endmodule

// ----- tb/tb_utf8_decode_filter.sv -----
// tb_utf8_decode_filter: self-checking bench for the streaming UTF-8 decode filter.
// Drives byte runs over valid/ready, predicts each result in-bench and compares in order.
// Depends on u8df_pkg and utf8_decode_filter.
module tb_utf8_decode_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import u8df_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            point_valid;
        logic            run_done;
        run_status_t     run_status;
    } point_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [20:0] m_code_point;
    logic        m_point_valid;
    logic        m_run_done;
    logic [1:0]  m_run_status;

    point_result_t   pending_points[$];
    logic [7:0]      run_bytes[$];
    int              mismatch_count = 0;
    bit              idle_on = 1'b1;
    int              hold_cycles = 0;

    logic [CP_W-1:0] acc_point = '0;
    logic [1:0]      cont_left = '0;
    logic            run_bad = 1'b0;
    logic            run_kept = 1'b0;

    utf8_decode_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_point_valid (m_point_valid),
        .m_run_done    (m_run_done),
        .m_run_status  (m_run_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic predict_decoded(input logic [7:0] b, input logic last);
        logic [CP_W-1:0] done_val;
        logic            done;
        logic            kept;
        logic [CP_W-1:0] out_cp;
        point_result_t   r;
        done = 1'b0;
        done_val = '0;
        kept = 1'b0;
        out_cp = '0;
        if (!run_bad) begin
            if (cont_left == 2'd0) begin
                casez (b)
                    8'b0???????: begin
                        done = 1'b1;
                        done_val = {{(CP_W-8){1'b0}}, b};
                    end
                    8'b110?????: begin
                        acc_point = {{(CP_W-5){1'b0}}, b[4:0]};
                        cont_left = 2'd1;
                    end
                    8'b1110????: begin
                        acc_point = {{(CP_W-4){1'b0}}, b[3:0]};
                        cont_left = 2'd2;
                    end
                    8'b11110???: begin
                        acc_point = {{(CP_W-3){1'b0}}, b[2:0]};
                        cont_left = 2'd3;
                    end
                    default: run_bad = 1'b1;
                endcase
            end else if (b[7:6] == 2'b10) begin
                acc_point = {acc_point[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    done = 1'b1;
                    done_val = acc_point;
                    acc_point = '0;
                end
            end else begin
                run_bad = 1'b1;
            end
            if (run_bad) begin
                acc_point = '0;
                cont_left = '0;
            end
            if (done) begin
                if (done_val > CP_MAX || (done_val >= CP_SURR_LO && done_val <= CP_SURR_HI)) begin
                    run_bad = 1'b1;
                end else if (done_val == CP_TAB || done_val == CP_LF || done_val == CP_CR) begin
                    kept = 1'b1;
                    out_cp = CP_SPACE;
                end else if (!(done_val < CP_SPACE || done_val == CP_DEL)) begin
                    kept = 1'b1;
                    out_cp = done_val;
                end
            end
        end
        if (last && cont_left != 2'd0) run_bad = 1'b1;
        if (run_bad) kept = 1'b0;
        if (kept) run_kept = 1'b1;
        if (kept || last) begin
            r.code_point = kept ? out_cp : '0;
            r.point_valid = kept;
            r.run_done = last;
            if (!last) r.run_status = RUN_OK;
            else if (run_bad) r.run_status = RUN_MALFORMED;
            else if (run_kept) r.run_status = RUN_OK;
            else r.run_status = RUN_EMPTY;
            pending_points = {pending_points, r};
        end
        if (last) begin
            acc_point = '0;
            cont_left = '0;
            run_bad = 1'b0;
            run_kept = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input point_result_t want);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected cp=%h pv=%b done=%b st=%0d, got cp=%h pv=%b done=%b st=%0d",
                     $time, what, want.code_point, want.point_valid, want.run_done,
                     want.run_status, m_code_point, m_point_valid, m_run_done, m_run_status);
        end
    endtask

    // Check before predicting: an input on the same edge never feeds this result.
    always @(posedge aclk) begin : track_transfers
        point_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                note_mismatch("unexpected result", '0);
            end else begin
                want = pending_points.pop_front();
                if (m_code_point !== want.code_point || m_point_valid !== want.point_valid ||
                    m_run_done !== want.run_done || m_run_status !== want.run_status) begin
                    note_mismatch("result mismatch", want);
                end
            end
        end
        if (aresetn && s_valid && s_ready) predict_decoded(s_data_byte, s_last_byte);
    end

    initial begin : result_sink
        int g;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
                m_ready <= 1'b1;
            end else begin
                g = pick_gap();
                if (g == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (g) @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_utf8_decode_filter NOT OK");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            s_data_byte <= 8'($urandom_range(255));
            s_last_byte <= 1'($urandom_range(1));
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_run();
        foreach (run_bytes[i]) send_byte(run_bytes[i], i == run_bytes.size() - 1);
    endtask

    task automatic add_random_point();
        int unsigned     r;
        int unsigned     n;
        int unsigned     keep;
        logic [CP_W-1:0] v;
        logic [7:0]      enc[4];
        r = $urandom_range(99);
        v = CP_W'($urandom());
        if (r < 5) begin
            run_bytes = {run_bytes, 8'($urandom_range(255))};
            return;
        end
        if (r < 45) n = 1;
        else if (r < 65) n = 2;
        else if (r < 85) n = 3;
        else n = 4;
        case (n)
            1: enc[0] = {1'b0, v[6:0]};
            2: begin
                enc[0] = {3'b110, v[10:6]};
                enc[1] = {2'b10, v[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, v[15:12]};
                enc[1] = {2'b10, v[11:6]};
                enc[2] = {2'b10, v[5:0]};
            end
            default: begin
                if ($urandom_range(9) != 0) v = CP_W'($urandom_range(32'h10FFFF));
                enc[0] = {5'b11110, v[20:18]};
                enc[1] = {2'b10, v[17:12]};
                enc[2] = {2'b10, v[11:6]};
                enc[3] = {2'b10, v[5:0]};
            end
        endcase
        keep = ($urandom_range(99) < 4 && n > 1) ? $urandom_range(n - 1, 1) : n;
        for (int i = 0; i < keep; i++) run_bytes = {run_bytes, enc[i]};
    endtask

    task automatic test_ascii_filtering();
        run_bytes = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h00, 8'h7F, 8'h7E};
        send_run();
        run_bytes = '{8'h7F};
        send_run();
    endtask

    task automatic test_multibyte_forms();
        // overlong 'A', U+0080, then the top code point
        run_bytes = '{8'hC1, 8'h81, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_run();
    endtask

    task automatic test_malformed_runs();
        run_bytes = '{8'hED, 8'hA0, 8'h80};
        send_run();
        run_bytes = '{8'hFF};
        send_run();
        run_bytes = '{8'hC3, 8'h41};
        send_run();
        run_bytes = '{8'hE2, 8'h82};
        send_run();
        run_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_run();
    endtask

    task automatic test_receiver_hold();
        idle_on = 1'b0;
        hold_cycles = HOLD_OFF_CYCLES;
        run_bytes.delete();
        repeat (40) run_bytes = {run_bytes, 8'($urandom_range(8'h7E, 8'h21))};
        send_run();
        idle_on = 1'b1;
    endtask

    task automatic test_random_runs();
        int unsigned sent;
        int unsigned runs;
        sent = 0;
        runs = 0;
        while (sent < 1400) begin
            idle_on = ((runs / 20) % 3) != 2;
            run_bytes.delete();
            repeat ($urandom_range(12, 1)) add_random_point();
            sent += run_bytes.size();
            send_run();
            runs++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_ascii_filtering();
        test_multibyte_forms();
        test_malformed_runs();
        test_receiver_hold();
        test_random_runs();

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_utf8_decode_filter OK");
        end else begin
            $display("tb_utf8_decode_filter NOT OK");
        end
        $finish;
    end

endmodule
